FILE: rtl/amrwb_pkg.sv
// ----------------------------------------------------------------------------
// amrwb_pkg
// Shared types, status codes and the frame size table for the AMR-WB
// payload deframer.
// ----------------------------------------------------------------------------
package amrwb_pkg;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_TYPE = 2'd1;
   localparam logic [1:0] STATUS_SHORT    = 2'd2;

   localparam logic [3:0] FT_SID_LAST = 4'd10;
   localparam logic [3:0] FT_LOST     = 4'he;
   localparam logic [3:0] FT_NO_DATA  = 4'hf;

   // result queue depth and pointer width
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic [1:0] status;
   } rsp_item_type;

   // speech bytes per frame type
   function automatic logic [5:0] frame_size(input logic [3:0] ft);
      logic [5:0] fs;
      case (ft)
         4'd0:    fs = 6'd17;
         4'd1:    fs = 6'd23;
         4'd2:    fs = 6'd32;
         4'd3:    fs = 6'd36;
         4'd4:    fs = 6'd40;
         4'd5:    fs = 6'd46;
         4'd6:    fs = 6'd50;
         4'd7:    fs = 6'd58;
         4'd8:    fs = 6'd60;
         4'd9:    fs = 6'd5;
         4'd14:   fs = 6'd1;
         4'd15:   fs = 6'd1;
         default: fs = 6'd0;
      endcase
      return fs;
   endfunction

endpackage

FILE: rtl/amrwb_unpack.sv
// ----------------------------------------------------------------------------
// amrwb_unpack
// Per-byte parser: tracks the packet position, extracts the TOC, realigns
// speech bytes and produces up to two results for each accepted byte.
// ----------------------------------------------------------------------------
module amrwb_unpack (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             in_byte,
   input  logic                   in_last,
   input  logic                   octet_aligned,
   output logic [1:0]             push_count,
   output amrwb_pkg::rsp_item_type item0,
   output amrwb_pkg::rsp_item_type item1
);
   import amrwb_pkg::*;

   logic [6:0] pos_ff, pos_in;
   logic       done_ff, done_in;
   logic [5:0] frame_bytes_ff, frame_bytes_in;
   logic [7:0] held_ff, held_in;

   logic [7:0] toc;
   logic [3:0] ft;
   logic [5:0] fs_new;
   logic [6:0] k;
   logic [6:0] fs_ext;
   logic [7:0] speech;
   logic [7:0] tail;

   assign toc    = octet_aligned ? in_byte : {held_ff[3:0], in_byte[7:4]};
   assign ft     = toc[6:3];
   assign fs_new = frame_size(ft);
   assign k      = pos_ff - 7'd2;
   assign fs_ext = {1'b0, frame_bytes_ff};
   assign speech = octet_aligned ? in_byte : {held_ff[5:0], in_byte[7:6]};
   assign tail   = {in_byte[5:0], 2'b00};

   always_comb begin
      pos_in         = pos_ff;
      done_in        = done_ff;
      frame_bytes_in = frame_bytes_ff;
      held_in        = held_ff;
      push_count     = 2'd0;
      item0          = '{data: 8'd0, last: 1'b1, status: STATUS_OK};
      item1          = '{data: tail, last: 1'b1, status: STATUS_OK};

      if (done_ff) begin
         // drop trailing bytes until the end of the packet
         if (in_last) begin
            pos_in  = 7'd0;
            done_in = 1'b0;
         end
      end else if (pos_ff == 7'd0) begin
         held_in = in_byte;
         if (in_last) begin
            push_count   = 2'd1;
            item0.status = STATUS_SHORT;
            pos_in       = 7'd0;
         end else begin
            pos_in = 7'd1;
         end
      end else if (pos_ff == 7'd1) begin
         if (ft > FT_SID_LAST && ft != FT_LOST && ft != FT_NO_DATA) begin
            push_count   = 2'd1;
            item0.status = STATUS_BAD_TYPE;
            pos_in       = 7'd0;
            done_in      = !in_last;
         end else begin
            frame_bytes_in = fs_new;
            if (fs_new == 6'd0) begin
               push_count = 2'd1;
               item0.data = toc;
               pos_in     = 7'd0;
               done_in    = !in_last;
            end else if (in_last) begin
               pos_in = 7'd0;
               if (!octet_aligned && fs_new == 6'd1) begin
                  push_count = 2'd2;
                  item0.data = toc;
                  item0.last = 1'b0;
               end else begin
                  push_count   = 2'd1;
                  item0.status = STATUS_SHORT;
               end
            end else begin
               push_count = 2'd1;
               item0.data = toc;
               item0.last = 1'b0;
               held_in    = in_byte;
               pos_in     = 7'd2;
            end
         end
      end else if (k >= fs_ext) begin
         pos_in  = 7'd0;
         done_in = !in_last;
      end else if (k == fs_ext - 7'd1) begin
         push_count = 2'd1;
         item0.data = speech;
         pos_in     = 7'd0;
         done_in    = !in_last;
      end else if (in_last) begin
         pos_in = 7'd0;
         if (!octet_aligned && k == fs_ext - 7'd2) begin
            // six bits left over: flush them zero-filled
            push_count = 2'd2;
            item0.data = speech;
            item0.last = 1'b0;
         end else begin
            push_count   = 2'd1;
            item0.status = STATUS_SHORT;
         end
      end else begin
         push_count = 2'd1;
         item0.data = speech;
         item0.last = 1'b0;
         held_in    = in_byte;
         if (pos_ff != 7'd127) begin
            pos_in = pos_ff + 7'd1;
         end
      end

      if (!accept) begin
         push_count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 7'd0;
         done_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_bytes_ff <= frame_bytes_in;
         held_ff        <= held_in;
      end
   end

endmodule

FILE: rtl/amrwb_rsp_queue.sv
// ----------------------------------------------------------------------------
// amrwb_rsp_queue
// Small result queue: takes zero, one or two results per cycle and hands
// out one per transaction on the result channel.
// ----------------------------------------------------------------------------
module amrwb_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_count,
   input  amrwb_pkg::rsp_item_type item0,
   input  amrwb_pkg::rsp_item_type item1,
   output logic                    full,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output amrwb_pkg::rsp_item_type head
);
   import amrwb_pkg::*;

   rsp_item_type         mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_PTR_W-1:0] wr_ptr_next;
   logic                 pop;

   assign rsp_valid   = count_ff != '0;
   assign head        = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   // hold off input unless two slots are free
   assign full        = count_ff > RSP_CNT_W'(RSP_DEPTH - 2);
   assign wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push_count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= item0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= item1;
      end
   end

endmodule

FILE: rtl/amrwb_payload_deframer.sv
// ----------------------------------------------------------------------------
// amrwb_payload_deframer
// Single-frame AMR-WB RTP payload deframer, octet-aligned or
// bandwidth-efficient.
// ----------------------------------------------------------------------------
// One payload byte is taken per clock cycle while req_stall is low. Each
// byte is parsed in the cycle it is accepted and its results (none, one,
// or two at the zero-filled end of a bandwidth-efficient frame) are
// written into a four-entry result queue, which drives the result channel
// one transaction per cycle while rsp_stall is low. Input is stalled
// whenever fewer than two queue slots are free; otherwise the sustained
// rate is one byte per cycle. Results are registered in the queue when
// the byte is accepted. The mode register is always writable (csr_ready
// is tied high) and is read on every byte.
// ----------------------------------------------------------------------------
module amrwb_payload_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic [1:0] rsp_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_octet_aligned
);
   import amrwb_pkg::*;

   logic         octet_aligned_ff;
   logic         accept;
   logic         full;
   logic [1:0]   push_count;
   rsp_item_type item0;
   rsp_item_type item1;
   rsp_item_type head;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         octet_aligned_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         octet_aligned_ff <= csr_octet_aligned;
      end
   end

   amrwb_unpack u_unpack (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_in_byte),
      .in_last       (req_in_last),
      .octet_aligned (octet_aligned_ff),
      .push_count    (push_count),
      .item0         (item0),
      .item1         (item1)
   );

   amrwb_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .item0      (item0),
      .item1      (item1),
      .full       (full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .head       (head)
   );

   assign rsp_out_byte = head.data;
   assign rsp_out_last = head.last;
   assign rsp_status   = head.status;

endmodule

FILE: dv/amrwb_payload_deframer_tb.sv
// ----------------------------------------------------------------------------
// amrwb_payload_deframer testbench
// Feeds AMR-WB payload bytes in both payload formats, first from a short
// table of hand-picked packets and then from randomly built packets, with
// random idle bursts on both channels. A behavioral deframer in this file
// predicts the results, but for table rows that give a fixed result or
// none; each result transaction is checked field by field in order.
// ----------------------------------------------------------------------------
module tb;
   import amrwb_pkg::*;

   localparam int RANDOM_ITEMS   = 1800;
   localparam int PHASE_ITEMS    = 300;
   localparam int NO_IDLE_ITEMS  = 250;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS    = 40;

   localparam logic [5:0] SPEECH_LEN [16] = '{
      6'd17, 6'd23, 6'd32, 6'd36, 6'd40, 6'd46, 6'd50, 6'd58,
      6'd60, 6'd5,  6'd0,  6'd0,  6'd0,  6'd0,  6'd1,  6'd1
   };

   typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_type;

   typedef struct packed {
      logic          mode;
      logic [7:0]    in_byte;
      logic          in_last;
      row_check_type chk;
      rsp_item_type  want;
   } dir_row_type;

   localparam rsp_item_type NO_RSP = '0;

   localparam dir_row_type DIR_ROWS [25] = '{
      // octet-aligned
      '{1'b1, 8'hF0, 1'b1, CHK_ONE,   '{8'h00, 1'b1, STATUS_SHORT}},    // one-byte packet
      '{1'b1, 8'hFF, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b1, 8'h58, 1'b0, CHK_ONE,   '{8'h00, 1'b1, STATUS_BAD_TYPE}}, // type 11
      '{1'b1, 8'hAA, 1'b1, CHK_NONE,  NO_RSP},
      '{1'b1, 8'h00, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b1, 8'h54, 1'b1, CHK_ONE,   '{8'h54, 1'b1, STATUS_OK}},       // type 10, no speech
      '{1'b1, 8'h00, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b1, 8'hFC, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b1, 8'h3C, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b1, 8'h81, 1'b1, CHK_NONE,  NO_RSP},                          // trailing byte
      '{1'b1, 8'h00, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b1, 8'h4C, 1'b1, CHK_ONE,   '{8'h00, 1'b1, STATUS_SHORT}},
      '{1'b1, 8'h7F, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b1, 8'h4C, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b1, 8'hFF, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b1, 8'h00, 1'b1, CHK_ONE,   '{8'h00, 1'b1, STATUS_SHORT}},
      // bandwidth-efficient
      '{1'b0, 8'hF7, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b0, 8'h4E, 1'b1, CHK_MODEL, NO_RSP},                          // zero-filled end
      '{1'b0, 8'h00, 1'b1, CHK_ONE,   '{8'h00, 1'b1, STATUS_SHORT}},    // one-byte packet
      '{1'b0, 8'h04, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b0, 8'hC3, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b0, 8'h5A, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b0, 8'hA5, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b0, 8'hFF, 1'b0, CHK_MODEL, NO_RSP},
      '{1'b0, 8'h00, 1'b1, CHK_MODEL, NO_RSP}                           // zero-filled end
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic [1:0] rsp_status;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_octet_aligned = 1'b1;

   // behavioral deframer state
   logic       pm_oa   = 1'b1;
   logic [6:0] pm_pos  = '0;
   logic [5:0] pm_len  = '0;
   logic [7:0] pm_prev = '0;
   logic       pm_done = 1'b0;

   rsp_item_type new_rsp [$];
   rsp_item_type due_rsp [$];

   int errors       = 0;
   int gap_pct      = 0;
   int stall_pct    = 0;
   int stall_left   = 0;
   int stuck_cycles = 0;
   bit no_idle      = 1'b0;

   amrwb_payload_deframer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_in_last       (req_in_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_out_last      (rsp_out_last),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_octet_aligned (csr_octet_aligned)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void emit(input logic [7:0] d, input logic l, input logic [1:0] s);
      new_rsp.push_back(rsp_item_type'{d, l, s});
   endfunction

   function automatic void end_frame(input logic last);
      if (last) begin
         pm_pos  = '0;
         pm_done = 1'b0;
      end else begin
         pm_done = 1'b1;
      end
   endfunction

   // Predict the results of one payload byte into new_rsp.
   function automatic void unpack_byte(input logic [7:0] b, input logic last);
      logic [7:0] toc;
      logic [7:0] word;
      logic [3:0] ft;
      int         k;
      int         fs;
      if (pm_done) begin
         if (last) end_frame(1'b1);
         return;
      end
      if (pm_pos == 7'd0) begin
         pm_prev = b;
         if (last) begin
            emit(8'h00, 1'b1, STATUS_SHORT);
            end_frame(1'b1);
         end else begin
            pm_pos = 7'd1;
         end
         return;
      end
      if (pm_pos == 7'd1) begin
         toc = pm_oa ? b : {pm_prev[3:0], b[7:4]};
         ft  = toc[6:3];
         if (ft > FT_SID_LAST && ft != FT_LOST && ft != FT_NO_DATA) begin
            emit(8'h00, 1'b1, STATUS_BAD_TYPE);
            end_frame(last);
            return;
         end
         pm_len = SPEECH_LEN[ft];
         if (pm_len == 6'd0) begin
            emit(toc, 1'b1, STATUS_OK);
            end_frame(last);
         end else if (last) begin
            if (!pm_oa && pm_len == 6'd1) begin
               emit(toc, 1'b0, STATUS_OK);
               emit({b[5:0], 2'b00}, 1'b1, STATUS_OK);
            end else begin
               emit(8'h00, 1'b1, STATUS_SHORT);
            end
            end_frame(1'b1);
         end else begin
            emit(toc, 1'b0, STATUS_OK);
            pm_prev = b;
            pm_pos  = 7'd2;
         end
         return;
      end
      k  = int'(pm_pos) - 2;
      fs = int'(pm_len);
      if (k >= fs) begin
         end_frame(last);
         return;
      end
      word = pm_oa ? b : {pm_prev[5:0], b[7:6]};
      if (k == fs - 1) begin
         emit(word, 1'b1, STATUS_OK);
         end_frame(last);
      end else if (last) begin
         // bandwidth-efficient packet one byte short of octet form: pad the tail
         if (!pm_oa && k == fs - 2) begin
            emit(word, 1'b0, STATUS_OK);
            emit({b[5:0], 2'b00}, 1'b1, STATUS_OK);
         end else begin
            emit(8'h00, 1'b1, STATUS_SHORT);
         end
         end_frame(1'b1);
      end else begin
         emit(word, 1'b0, STATUS_OK);
         pm_prev = b;
         if (pm_pos < 7'd127) pm_pos = pm_pos + 7'd1;
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last, input row_check_type chk,
                            input rsp_item_type want);
      if (!no_idle && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (req_stall);
      new_rsp.delete();
      unpack_byte(b, last);
      case (chk)
         CHK_MODEL: begin
            foreach (new_rsp[i]) due_rsp.push_back(new_rsp[i]);
         end
         CHK_ONE: begin
            due_rsp.push_back(want);
         end
         default: begin
         end
      endcase
   endtask

   // Write the mode only with the block drained.
   task automatic set_mode(input logic oa);
      req_valid <= 1'b0;
      while (due_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_octet_aligned <= oa;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pm_oa = oa;
   endtask

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // random result stall bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!no_idle && $urandom_range(99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_byte, rsp_out_last, rsp_status};
         if (due_rsp.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected transaction, expected none, got %0h %0b %0d",
                        $time, got.data, got.last, got.status);
         end else begin
            want = due_rsp.pop_front();
            check_field("out_byte", want.data, got.data);
            check_field("out_last", {7'd0, want.last}, {7'd0, got.last});
            check_field("status", {6'd0, want.status}, {6'd0, got.status});
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL amrwb_payload_deframer");
         $finish;
      end
   end

   initial begin
      int         n_items;
      int         next_phase;
      int         phase;
      int         need;
      int         len;
      int         pick;
      bit         noise;
      logic       pkt_oa;
      logic [3:0] ft;
      logic [7:0] toc;
      logic [7:0] b;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      gap_pct   = 20;
      stall_pct = 20;
      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].mode != pm_oa) set_mode(DIR_ROWS[i].mode);
         send_byte(DIR_ROWS[i].in_byte, DIR_ROWS[i].in_last, DIR_ROWS[i].chk, DIR_ROWS[i].want);
      end

      n_items    = 0;
      phase      = 0;
      next_phase = PHASE_ITEMS;
      while (n_items < RANDOM_ITEMS) begin
         pkt_oa = pm_oa;
         pick   = $urandom_range(19);
         // favor short frame types, keep some full-rate and some rejected ones
         if (pick < 10) begin
            case ($urandom_range(3))
               0:       ft = 4'd9;
               1:       ft = FT_SID_LAST;
               2:       ft = FT_LOST;
               default: ft = FT_NO_DATA;
            endcase
         end else if (pick < 17) begin
            ft = 4'($urandom_range(8));
         end else begin
            ft = 4'($urandom_range(13, 11));
         end
         toc      = 8'($urandom_range(255));
         toc[6:3] = ft;
         need     = int'(SPEECH_LEN[ft]) + (pkt_oa ? 2 : 1);
         if (need < 2) need = 2;
         noise = ($urandom_range(9) == 0);
         pick  = $urandom_range(19);
         if (noise)
            len = $urandom_range(6, 1);
         else if (pick < 14)
            len = need;
         else if (pick < 17)
            len = need + $urandom_range(3, 1);
         else
            len = $urandom_range(need - 1, 1);

         for (int j = 0; j < len; j++) begin
            b = 8'($urandom_range(255));
            if (!noise) begin
               if (pkt_oa) begin
                  if (j == 1) b = toc;
               end else begin
                  if (j == 0) b = {b[7:4], toc[7:4]};
                  else if (j == 1) b = {toc[3:0], b[3:0]};
               end
            end
            send_byte(b, j == len - 1, CHK_MODEL, NO_RSP);
            n_items++;
            no_idle = (n_items >= RANDOM_ITEMS - NO_IDLE_ITEMS);
            // new phase: may land mid-packet
            if (n_items >= next_phase) begin
               phase++;
               next_phase += PHASE_ITEMS;
               set_mode(phase % 2 == 1);
               case ($urandom_range(2))
                  0:       gap_pct = 0;
                  1:       gap_pct = 15;
                  default: gap_pct = 45;
               endcase
               case ($urandom_range(2))
                  0:       stall_pct = 0;
                  1:       stall_pct = 15;
                  default: stall_pct = 45;
               endcase
            end
         end
      end
      req_valid <= 1'b0;

      while (due_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && due_rsp.size() == 0)
         $display("PASS amrwb_payload_deframer");
      else
         $display("FAIL amrwb_payload_deframer");
      $finish;
   end

endmodule
